@@ hdl/cbsa_pkg.sv @@
// cbsa_pkg: types, constants and helpers for the class band statistics accumulator.
// Used by cbsa_lane and class_band_statistics_accumulator_top.
package cbsa_pkg;

   localparam int CLASSES     = 16;
   localparam int BANDS       = 8;
   localparam int BINS        = 256;
   localparam int PAIRS       = BANDS * (BANDS + 1) / 2;
   localparam int CLASS_W     = 4;
   localparam int BAND_W      = 3;
   localparam int BIN_W       = 8;
   localparam int PAIR_W      = 6;
   localparam int HIST_DEPTH  = CLASSES * BANDS * BINS;
   localparam int HIST_AW     = CLASS_W + BAND_W + BIN_W;
   localparam int CLEAR_W     = CLASS_W + BIN_W;
   localparam int CLEAR_LAST  = CLASSES * BINS - 1;
   localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_SUMS   = 2'd2,
      KIND_BIN    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_READ  = 2'd2,
      ST_WRITE = 2'd3
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  class_label;
      logic [2:0]  band_a;
      logic [7:0]  index_b;
      logic [7:0]  band_value_0;
      logic [7:0]  band_value_1;
      logic [7:0]  band_value_2;
      logic [7:0]  band_value_3;
      logic [7:0]  band_value_4;
      logic [7:0]  band_value_5;
      logic [7:0]  band_value_6;
      logic [7:0]  band_value_7;
   } req_type;

   typedef struct packed {
      logic [23:0] sample_count;
      logic [31:0] band_sum;
      logic [39:0] product_sum;
      logic [23:0] bin_count;
   } rsp_type;

   // lane control from the sequencer
   typedef struct packed {
      logic               clear;
      logic               rd;
      logic               wr;
      logic               add;
      logic [CLASS_W-1:0] cls;
      logic [CLEAR_W-1:0] clr_addr;
   } lane_ctl_type;

   function automatic logic [PAIR_W-1:0] pair_slot(input logic [BAND_W-1:0] a,
                                                   input logic [BAND_W-1:0] b);
      logic [PAIR_W-1:0] lo;
      logic [PAIR_W-1:0] hi;
      lo = (a < b) ? PAIR_W'(a) : PAIR_W'(b);
      hi = (a < b) ? PAIR_W'(b) : PAIR_W'(a);
      return PAIR_W'(lo * PAIR_W'(BANDS) - ((lo * (lo - ((lo != '0) ? 1 : 0))) >> 1)
                     + (hi - lo));
   endfunction

endpackage

@@ hdl/cbsa_ram.sv @@
// cbsa_ram: generic single-port write, single read RAM with registered read.
// No dependencies.
module cbsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/cbsa_lane.sv @@
// cbsa_lane: one band's storage and update path: band sum, histogram and the
// pair sums whose lower band is this lane. Depends on cbsa_pkg, cbsa_ram.
module cbsa_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  cbsa_pkg::lane_ctl_type         ctl,
   input  logic [2:0]                     lane_idx,
   input  logic                           lane_on,
   input  logic [7:0]                     vals [8],
   input  logic [7:0]                     q_bin,
   input  logic [2:0]                     q_partner,
   output logic [31:0]                    sum_q,
   output logic [23:0]                    bin_q,
   output logic [39:0]                    pair_q
);
   import cbsa_pkg::*;

   logic [7:0]          my_val;
   logic [BIN_W-1:0]    hbin;
   logic [CLASS_W+BIN_W-1:0] h_rd_addr;
   logic [CLASS_W+BIN_W-1:0] h_wr_addr;
   logic [23:0]         h_rd;
   logic [23:0]         h_wd;
   logic [31:0]         s_rd;
   logic [31:0]         s_wd;
   logic [39:0]         p_rd [BANDS];
   logic [39:0]         p_wd [BANDS];
   logic                wr_lane;
   logic [2:0]          partner_ff;

   assign my_val  = vals[lane_idx];
   assign hbin    = my_val;
   assign wr_lane = ctl.wr && lane_on;

   // during updates read at the pixel's bin, during queries at the asked bin
   assign h_rd_addr = ctl.rd ? {ctl.cls, hbin} : {ctl.cls, q_bin};
   assign h_wr_addr = ctl.clear ? ctl.clr_addr : {ctl.cls, hbin};
   assign h_wd = ctl.clear ? '0 : (ctl.add ? h_rd + 24'd1 : h_rd - 24'd1);
   assign s_wd = ctl.clear ? '0 : (ctl.add ? s_rd + 32'(my_val) : s_rd - 32'(my_val));

   cbsa_ram #(.WIDTH(24), .DEPTH(CLASSES * BINS)) u_hist (
      .clock   (clock),
      .wr_en   (ctl.clear || wr_lane),
      .wr_addr (h_wr_addr),
      .wr_data (h_wd),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd)
   );

   cbsa_ram #(.WIDTH(32), .DEPTH(CLASSES)) u_sum (
      .clock   (clock),
      .wr_en   ((ctl.clear && ctl.clr_addr[BIN_W-1:0] == '0) || wr_lane),
      .wr_addr (ctl.clear ? ctl.clr_addr[CLEAR_W-1 -: CLASS_W] : ctl.cls),
      .wr_data (s_wd),
      .rd_addr (ctl.cls),
      .rd_data (s_rd)
   );

   // one pair column per partner band; only partners at or above this lane are used
   for (genvar g = 0; g < BANDS; g++) begin : g_pair
      logic [15:0] prod;
      logic        pw;
      assign prod = 16'(my_val) * 16'(vals[g]);
      // partners beyond the active bands carry zero values, so their sums stay put
      assign pw   = wr_lane && (3'(g) >= lane_idx);
      assign p_wd[g] = ctl.clear ? '0 :
                       (ctl.add ? p_rd[g] + 40'(prod) : p_rd[g] - 40'(prod));
      cbsa_ram #(.WIDTH(40), .DEPTH(CLASSES)) u_pair (
         .clock   (clock),
         .wr_en   ((ctl.clear && ctl.clr_addr[BIN_W-1:0] == '0) || pw),
         .wr_addr (ctl.clear ? ctl.clr_addr[CLEAR_W-1 -: CLASS_W] : ctl.cls),
         .wr_data (p_wd[g]),
         .rd_addr (ctl.cls),
         .rd_data (p_rd[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partner_ff <= '0;
      end else begin
         partner_ff <= q_partner;
      end
   end

   assign sum_q  = s_rd;
   assign bin_q  = h_rd;
   assign pair_q = p_rd[partner_ff];
endmodule

@@ hdl/class_band_statistics_accumulator_top.sv @@
// class_band_statistics_accumulator_top: per-class band statistics over per-band lanes.
//   channel | dir | payload
//   req_    | in  | req_type, one pixel update or query
//   rsp_    | out | rsp_type, one result per query
//   csr_    | in  | bands_in_use, 4 bits
// Each item passes accept, RAM read, then write or respond, and the next item
// waits until these are done. After reset a clearing pass over CLASSES*BINS =
// 4096 addresses wipes the histograms; no item is accepted meanwhile. A held
// result blocks further items. Depends on cbsa_pkg, cbsa_lane, cbsa_ram.
module class_band_statistics_accumulator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbsa_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [3:0]        csr_wdata
);
   import cbsa_pkg::*;

   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic [3:0]       bands_ff;
   logic [CLEAR_W-1:0] clr_ff, clr_in;
   logic [23:0]      cnt_ff [CLASSES];
   logic             do_upd_ff, do_upd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   lane_ctl_type     ctl;
   logic [7:0]       vals [8];
   logic [2:0]       nact;
   logic [31:0]      sum_q [BANDS];
   logic [23:0]      bin_q [BANDS];
   logic [39:0]      pair_q [BANDS];
   logic [2:0]       lo_b, hi_b;
   logic             accept;
   logic [23:0]      cur_cnt;

   assign vals = '{item_ff.band_value_0, item_ff.band_value_1, item_ff.band_value_2,
                   item_ff.band_value_3, item_ff.band_value_4, item_ff.band_value_5,
                   item_ff.band_value_6, item_ff.band_value_7};
   assign nact = (bands_ff == 4'd0) ? 3'd0 : ((bands_ff > 4'd8) ? 3'd7 : 3'(bands_ff - 4'd1));
   assign lo_b = (item_ff.band_a < item_ff.index_b[2:0]) ? item_ff.band_a : item_ff.index_b[2:0];
   assign hi_b = (item_ff.band_a < item_ff.index_b[2:0]) ? item_ff.index_b[2:0] : item_ff.band_a;
   assign cur_cnt = cnt_ff[item_ff.class_label];

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ctl.clear    = (state_ff == ST_CLEAR);
      ctl.rd       = (state_ff == ST_READ) &&
                     (item_ff.kind == KIND_ADD || item_ff.kind == KIND_REMOVE);
      ctl.wr       = (state_ff == ST_WRITE) && do_upd_ff;
      ctl.add      = (item_ff.kind == KIND_ADD);
      ctl.cls      = (state_ff == ST_IDLE) ? req_data.class_label : item_ff.class_label;
      ctl.clr_addr = clr_ff;
   end

   for (genvar l = 0; l < BANDS; l++) begin : g_lane
      lane_ctl_type lctl;
      logic [7:0]   lvals [8];
      always_comb begin
         lctl = ctl;
         // partners beyond the active bands see zero product only via mask below
         for (int i = 0; i < 8; i++) begin
            lvals[i] = (3'(i) <= nact) ? vals[i] : 8'd0;
         end
      end
      cbsa_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lctl),
         .lane_idx  (3'(l)),
         .lane_on   (3'(l) <= nact),
         .vals      (lvals),
         .q_bin     ((state_ff == ST_IDLE) ? req_data.index_b : item_ff.index_b),
         .q_partner ((state_ff == ST_IDLE) ?
                     ((req_data.band_a < req_data.index_b[2:0]) ? req_data.index_b[2:0]
                                                                 : req_data.band_a)
                     : hi_b),
         .sum_q     (sum_q[l]),
         .bin_q     (bin_q[l]),
         .pair_q    (pair_q[l])
      );
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      clr_in       = clr_ff;
      do_upd_in    = do_upd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLEAR_W'(CLEAR_LAST)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            do_upd_in = (item_ff.kind == KIND_ADD && cur_cnt != COUNT_MAX) ||
                        (item_ff.kind == KIND_REMOVE && cur_cnt != 24'd0);
            if (item_ff.kind == KIND_ADD || item_ff.kind == KIND_REMOVE) begin
               state_in = ST_WRITE;
            end else begin
               rsp_in = '0;
               rsp_in.sample_count = cur_cnt;
               if (item_ff.kind == KIND_SUMS) begin
                  rsp_in.band_sum = sum_q[item_ff.band_a];
                  if (item_ff.index_b < 8'(BANDS)) begin
                     rsp_in.product_sum = pair_q[lo_b];
                  end
               end else begin
                  rsp_in.bin_count = bin_q[item_ff.band_a];
               end
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bands_ff     <= 4'd8;
         rsp_valid_ff <= 1'b0;
         do_upd_ff    <= 1'b0;
         for (int c = 0; c < CLASSES; c++) begin
            cnt_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         do_upd_ff    <= do_upd_in;
         if (csr_we) begin
            bands_ff <= csr_wdata;
         end
         if (ctl.wr) begin
            cnt_ff[item_ff.class_label] <= ctl.add ? cur_cnt + 24'd1 : cur_cnt - 24'd1;
         end
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready) else $error("item taken during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready) else $error("second item taken");
`endif
endmodule
